/* design/isu_pkg.sv */
`default_nettype none
package isu_pkg;

    // item operation codes
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_FLIP  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // result status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_LEN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUPLING  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROB_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PROB_HIGH = 2'd3;

    // field widths
    localparam int SIDE_W   = 7;
    localparam int COUP_W   = 5;
    localparam int PROB_W   = 17;
    localparam int COORD_W  = 6;
    localparam int ENERGY_W = 18;
    localparam int MAG_W    = 14;
    localparam int CFG_W    = 17;
    localparam int DE_W     = 10;

    // register reset values
    localparam logic [SIDE_W-1:0]        SIDE_RST      = 7'd16;
    localparam logic signed [COUP_W-1:0] COUP_RST      = 5'sd1;
    localparam logic [PROB_W-1:0]        PROB_LOW_RST  = 17'd1200;
    localparam logic [PROB_W-1:0]        PROB_HIGH_RST = 17'd22;

    // totals for an all-up lattice under the reset registers
    localparam logic signed [ENERGY_W-1:0] ENERGY_RST = -18'sd512;
    localparam logic signed [MAG_W-1:0]    MAG_RST    = 14'sd256;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_UP,
        ST_RD_DN,
        ST_RD_MID,
        ST_EVAL,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

/* design/isu_lattice_mem.sv */
`default_nettype none
module isu_lattice_mem
    import isu_pkg::*;
#(
    parameter int MAX_SIDE = 64
) (
    input  wire                               i_clk,
    input  wire                               i_we,
    input  wire  [$clog2(MAX_SIDE)-1:0]       i_waddr,
    input  wire  [MAX_SIDE-1:0]               i_wdata,
    input  wire  [$clog2(MAX_SIDE)-1:0]       i_raddr,
    output logic [MAX_SIDE-1:0]               o_rdata
);

    // one lattice row per word, bit set means spin up
    logic [MAX_SIDE-1:0] r_mem [MAX_SIDE];

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* design/ising_metropolis_spin_update_core.sv */
`default_nettype none
// sequence: a write or flip item reads the row above, the row below and its own
//   row, then evaluates and writes the row back; a bad coordinate or unused code
//   posts its result directly, a clear first sweeps all MAX_SIDE rows
// throughput: one item at a time; the next item is taken in the cycle after the
//   result is posted; a write or flip is paced by its three row reads and one row
//   write through the lattice memory; a stalled result holds the block until it is taken
// reset: synchronous active low; a row-by-row sweep of all MAX_SIDE rows sets the
//   lattice to all up, no item is accepted meanwhile (config writes are taken)
module ising_metropolis_spin_update_core
    import isu_pkg::*;
#(
    parameter int MAX_SIDE  = 64,
    parameter int PROB_BITS = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    // item input channel
    input  wire                         i_valid,
    output logic                        o_stall,
    input  wire  [1:0]                  i_func,
    input  wire  [COORD_W-1:0]          i_row,
    input  wire  [COORD_W-1:0]          i_col,
    input  wire                         i_spin_value,
    input  wire  [PROB_BITS-1:0]        i_random_draw,
    // result output channel
    output logic                        o_valid,
    input  wire                         i_stall,
    output logic                        o_accepted,
    output logic                        o_status,
    output logic signed [ENERGY_W-1:0]  o_energy,
    output logic signed [MAG_W-1:0]     o_magnetization,
    // configuration write channel
    input  wire                         i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [CFG_W-1:0]            i_cfg_data
);

    localparam int AW  = $clog2(MAX_SIDE);
    localparam int NW  = $clog2(MAX_SIDE + 1);
    localparam int SQW = 2 * NW;
    localparam int CW  = (PROB_BITS > PROB_W) ? PROB_BITS : PROB_W;
    localparam int EW  = SQW + COUP_W + 2;

    // totals for an all-up lattice under the reset registers and this lattice size
    localparam int RST_SIDE = (int'(SIDE_RST) > MAX_SIDE) ? MAX_SIDE : int'(SIDE_RST);
    localparam logic signed [ENERGY_W-1:0] RST_ENERGY =
        ENERGY_W'(-2 * int'(COUP_RST) * RST_SIDE * RST_SIDE);
    localparam logic signed [MAG_W-1:0]    RST_MAG    = MAG_W'(RST_SIDE * RST_SIDE);

    // configuration registers
    logic [SIDE_W-1:0]        r_side_len;
    logic signed [COUP_W-1:0] r_coupling;
    logic [PROB_W-1:0]        r_prob_low;
    logic [PROB_W-1:0]        r_prob_high;

    // sequencer and item registers
    t_state                   r_state, n_state;
    logic [AW-1:0]            r_clr_cnt;
    logic                     r_clr_item;
    logic [SQW-1:0]           r_sq;
    logic [1:0]               r_func;
    logic                     r_spin;
    logic [PROB_BITS-1:0]     r_draw;
    logic [AW-1:0]            r_row, r_col, r_up, r_dn, r_left, r_right;
    logic                     r_up_bit, r_dn_bit;
    logic                     r_res_acc, r_res_status;
    logic signed [ENERGY_W-1:0] r_energy;
    logic signed [MAG_W-1:0]    r_mag;

    // memory port
    logic                mem_we;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    logic [MAX_SIDE-1:0] mem_wdata, mem_rdata;

    // effective side and accept-time decode
    logic [NW-1:0]       side_n;
    logic                in_take, out_take, coord_bad;
    logic [AW-1:0]       row_a, col_a;

    // evaluation datapath
    logic                s_bit, l_bit, rt_bit, flip, draw_ok, de_pos, far_high;
    logic [2:0]          up_cnt;
    logic signed [4:0]   ns, sns;
    logic signed [DE_W-1:0] de;
    logic [PROB_W-1:0]   prob_sel;
    logic signed [EW-1:0] clr_prod;
    logic                last_row;

    isu_lattice_mem #(
        .MAX_SIDE (MAX_SIDE)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != ST_IDLE);
    assign in_take     = i_valid && !o_stall;
    assign out_take    = o_valid && !i_stall;
    assign last_row    = (r_clr_cnt == AW'(MAX_SIDE - 1));

    // side length clamped to the supported range
    always_comb begin
        if (int'(r_side_len) < 2) begin
            side_n = NW'(2);
        end else if (int'(r_side_len) > MAX_SIDE) begin
            side_n = NW'(MAX_SIDE);
        end else begin
            side_n = NW'(r_side_len);
        end
    end

    assign coord_bad = (int'(i_row) >= int'(side_n)) || (int'(i_col) >= int'(side_n));
    assign row_a     = AW'(i_row);
    assign col_a     = AW'(i_col);

    // spin evaluation on the centre row
    always_comb begin
        s_bit    = mem_rdata[r_col];
        l_bit    = mem_rdata[r_left];
        rt_bit   = mem_rdata[r_right];
        up_cnt   = 3'(r_up_bit) + 3'(r_dn_bit) + 3'(l_bit) + 3'(rt_bit);
        ns       = $signed({1'b0, up_cnt, 1'b0}) - 5'sd4;
        sns      = s_bit ? ns : -ns;
        de       = (DE_W'(r_coupling) * DE_W'(sns)) <<< 1;
        de_pos   = !de[DE_W-1] && (de != '0);
        far_high = (up_cnt == 3'd0) || (up_cnt == 3'd4);
        prob_sel = far_high ? r_prob_high : r_prob_low;
        draw_ok  = (CW'(r_draw) <= CW'(prob_sel));
        if (r_func == FUNC_WRITE) begin
            flip = (r_spin != s_bit);
        end else begin
            flip = !de_pos || draw_ok;
        end
    end

    // energy product for a cleared lattice
    assign clr_prod = EW'($signed({1'b0, r_sq})) * EW'(r_coupling);

    // next state and memory controls
    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_waddr = r_row;
        mem_wdata = mem_rdata ^ (MAX_SIDE'(1) << r_col);
        mem_raddr = r_row;
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_cnt;
                mem_wdata = '1;
                if (last_row) begin
                    n_state = r_clr_item ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_take) begin
                    if (i_func == FUNC_CLEAR) begin
                        n_state = ST_CLEAR;
                    end else if (i_func == FUNC_WRITE || i_func == FUNC_FLIP) begin
                        n_state = coord_bad ? ST_DONE : ST_RD_UP;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_RD_UP: begin
                mem_raddr = r_up;
                n_state   = ST_RD_DN;
            end
            ST_RD_DN: begin
                mem_raddr = r_dn;
                n_state   = ST_RD_MID;
            end
            ST_RD_MID: begin
                mem_raddr = r_row;
                n_state   = ST_EVAL;
            end
            ST_EVAL: begin
                mem_we  = flip;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!o_valid || !i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state, totals and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_cnt    <= '0;
            r_clr_item   <= 1'b0;
            r_energy     <= RST_ENERGY;
            r_mag        <= RST_MAG;
            r_res_acc    <= 1'b0;
            r_res_status <= STATUS_OK;
            o_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            // result valid: set as a result is posted, cleared when taken
            if (r_state == ST_DONE && (!o_valid || !i_stall)) begin
                o_valid <= 1'b1;
            end else if (out_take) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + AW'(1);
                    if (last_row && r_clr_item) begin
                        r_energy <= ENERGY_W'(-(clr_prod <<< 1));
                        r_mag    <= MAG_W'(r_sq);
                    end
                end
                ST_IDLE: begin
                    r_res_acc    <= 1'b0;
                    r_res_status <= (in_take && coord_bad
                                     && (i_func == FUNC_WRITE || i_func == FUNC_FLIP))
                                    ? STATUS_RANGE : STATUS_OK;
                    r_clr_item   <= in_take && (i_func == FUNC_CLEAR);
                    r_clr_cnt    <= '0;
                end
                ST_EVAL: begin
                    r_res_acc <= (r_func == FUNC_FLIP) && flip;
                    if (flip) begin
                        r_energy <= r_energy + ENERGY_W'(de);
                        r_mag    <= s_bit ? (r_mag - MAG_W'(2)) : (r_mag + MAG_W'(2));
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result payload, loaded as the result is posted
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && (!o_valid || !i_stall)) begin
            o_accepted      <= r_res_acc;
            o_status        <= r_res_status;
            o_energy        <= r_energy;
            o_magnetization <= r_mag;
        end
    end

    // item payload and neighbor addresses captured on accept
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_func  <= i_func;
            r_spin  <= i_spin_value;
            r_draw  <= i_random_draw;
            r_row   <= row_a;
            r_col   <= col_a;
            r_sq    <= SQW'(side_n) * SQW'(side_n);
            r_up    <= (row_a == '0) ? AW'(side_n - NW'(1)) : (row_a - AW'(1));
            r_dn    <= (int'(row_a) + 1 == int'(side_n)) ? '0 : (row_a + AW'(1));
            r_left  <= (col_a == '0) ? AW'(side_n - NW'(1)) : (col_a - AW'(1));
            r_right <= (int'(col_a) + 1 == int'(side_n)) ? '0 : (col_a + AW'(1));
        end
        // neighbor spins above and below
        if (r_state == ST_RD_DN) begin
            r_up_bit <= mem_rdata[r_col];
        end
        if (r_state == ST_RD_MID) begin
            r_dn_bit <= mem_rdata[r_col];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_len  <= SIDE_RST;
            r_coupling  <= COUP_RST;
            r_prob_low  <= PROB_LOW_RST;
            r_prob_high <= PROB_HIGH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_SIDE_LEN:  r_side_len  <= i_cfg_data[SIDE_W-1:0];
                REG_COUPLING:  r_coupling  <= $signed(i_cfg_data[COUP_W-1:0]);
                REG_PROB_LOW:  r_prob_low  <= i_cfg_data[PROB_W-1:0];
                REG_PROB_HIGH: r_prob_high <= i_cfg_data[PROB_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import isu_pkg::*;

    localparam int MAX_SIDE        = 64;
    localparam int PROB_BITS       = 16;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 134;
    localparam int SETTLE_CYCLES   = MAX_SIDE + 8;
    localparam int CYCLE_LIMIT     = 1000000;

    // unused operation code, treated as a no-op
    localparam logic [1:0] FUNC_NOP = 2'd3;

    typedef struct packed {
        logic [1:0]           func;
        logic [COORD_W-1:0]   row;
        logic [COORD_W-1:0]   col;
        logic                 spin_value;
        logic [PROB_BITS-1:0] random_draw;
    } t_spin_item;

    typedef struct packed {
        logic                accepted;
        logic                status;
        logic [ENERGY_W-1:0] energy;
        logic [MAG_W-1:0]    magnetization;
    } t_spin_result;

    typedef struct packed {
        t_spin_item   item;
        logic         typed;
        t_spin_result res;
    } t_dir_row;

    typedef struct packed {
        logic [SIDE_W-1:0]        side;
        logic signed [COUP_W-1:0] coup;
        logic [PROB_W-1:0]        plo;
        logic [PROB_W-1:0]        phi;
    } t_lattice_cfg;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // block ports
    logic                        i_valid       = 1'b0;
    logic                        o_stall;
    logic [1:0]                  i_func        = '0;
    logic [COORD_W-1:0]          i_row         = '0;
    logic [COORD_W-1:0]          i_col         = '0;
    logic                        i_spin_value  = 1'b0;
    logic [PROB_BITS-1:0]        i_random_draw = '0;
    logic                        o_valid;
    logic                        i_stall       = 1'b0;
    logic                        o_accepted;
    logic                        o_status;
    logic signed [ENERGY_W-1:0]  o_energy;
    logic signed [MAG_W-1:0]     o_magnetization;
    logic                        i_cfg_valid   = 1'b0;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index   = '0;
    logic [CFG_W-1:0]            i_cfg_data    = '0;

    ising_metropolis_spin_update_core #(
        .MAX_SIDE (MAX_SIDE),
        .PROB_BITS(PROB_BITS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_spin_value   (i_spin_value),
        .i_random_draw  (i_random_draw),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_accepted     (o_accepted),
        .o_status       (o_status),
        .o_energy       (o_energy),
        .o_magnetization(o_magnetization),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // typed expectation riding along with the item in flight
    logic         item_typed     = 1'b0;
    t_spin_result item_typed_res = '0;

    // lattice copy, totals and registers as the block should hold them
    bit                         spin_up [0:MAX_SIDE*MAX_SIDE-1];
    logic signed [ENERGY_W-1:0] energy_tot;
    logic signed [MAG_W-1:0]    mag_tot;
    logic [SIDE_W-1:0]          side_len;
    logic signed [COUP_W-1:0]   coupling;
    logic [PROB_W-1:0]          prob_low;
    logic [PROB_W-1:0]          prob_high;

    t_spin_result results_due [$];
    t_dir_row     directed_rows [$];
    t_lattice_cfg settings [$];

    int err_cnt      = 0;
    int items_sent   = 0;
    int checked_cnt  = 0;
    int reg_writes   = 0;
    int flips_taken  = 0;
    int range_errors = 0;
    int clears_seen  = 0;
    int cycle_cnt    = 0;
    int send_idle    = 15;
    int recv_idle    = 73;
    int total_items;

    function automatic int side_eff();
        if (side_len < 2) return 2;
        if (side_len > MAX_SIDE) return MAX_SIDE;
        return int'(side_len);
    endfunction

    function automatic int spin_val(input int r, input int c);
        return spin_up[r*MAX_SIDE + c] ? 1 : -1;
    endfunction

    // all spins up, totals recomputed from the current registers
    function automatic void clear_lattice();
        int n;
        n = side_eff();
        foreach (spin_up[i]) spin_up[i] = 1'b1;
        energy_tot = ENERGY_W'(-2 * int'(coupling) * n * n);
        mag_tot    = MAG_W'(n * n);
    endfunction

    // one metropolis step on the lattice copy
    function automatic t_spin_result metropolis_step(input t_spin_item it);
        int n, r, c, up, dn, lf, rt, s, ns, de, a, p;
        bit flip;
        t_spin_result res;
        n = side_eff();
        r = int'(it.row);
        c = int'(it.col);
        flip = 1'b0;
        res.accepted = 1'b0;
        res.status   = STATUS_OK;
        if (it.func == FUNC_CLEAR) begin
            clear_lattice();
        end else if (it.func == FUNC_WRITE || it.func == FUNC_FLIP) begin
            if (r >= n || c >= n) begin
                res.status = STATUS_RANGE;
            end else begin
                // periodic neighbors
                up = (r == 0) ? n - 1 : r - 1;
                dn = (r + 1 == n) ? 0 : r + 1;
                lf = (c == 0) ? n - 1 : c - 1;
                rt = (c + 1 == n) ? 0 : c + 1;
                s  = spin_val(r, c);
                ns = spin_val(up, c) + spin_val(dn, c) + spin_val(r, lf) + spin_val(r, rt);
                de = 2 * int'(coupling) * s * ns;
                if (it.func == FUNC_WRITE) begin
                    flip = ((it.spin_value ? 1 : -1) != s);
                end else begin
                    if (de <= 0) begin
                        flip = 1'b1;
                    end else begin
                        a = (ns < 0) ? -ns : ns;
                        p = (a >= 4) ? int'(prob_high) : int'(prob_low);
                        flip = (int'(it.random_draw) <= p);
                    end
                    res.accepted = flip;
                end
                if (flip) begin
                    spin_up[r*MAX_SIDE + c] = ~spin_up[r*MAX_SIDE + c];
                    energy_tot = ENERGY_W'(int'(energy_tot) + de);
                    mag_tot    = MAG_W'(int'(mag_tot) - 2 * s);
                end
            end
        end
        res.energy        = energy_tot;
        res.magnetization = mag_tot;
        return res;
    endfunction

    function automatic logic [PROB_BITS-1:0] near_prob(input logic [PROB_W-1:0] p);
        int v;
        v = int'(p) + int'($urandom_range(2)) - 1;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return PROB_BITS'(v);
    endfunction

    // random item: mostly in-range writes and flips, some clears, no-ops, bad coordinates
    function automatic t_spin_item random_item();
        t_spin_item it;
        int n, k, lim;
        n = side_eff();
        k = $urandom_range(99);
        if (k < 5) it.func = FUNC_CLEAR;
        else if (k < 9) it.func = FUNC_NOP;
        else if (k < 35) it.func = FUNC_WRITE;
        else it.func = FUNC_FLIP;
        lim = ($urandom_range(9) == 0) ? MAX_SIDE - 1 : n - 1;
        it.row = COORD_W'($urandom_range(lim));
        it.col = COORD_W'($urandom_range(lim));
        it.spin_value = 1'($urandom_range(1));
        case ($urandom_range(3))
            0: it.random_draw = PROB_BITS'($urandom_range(65535));
            1: it.random_draw = PROB_BITS'($urandom_range(255));
            2: it.random_draw = near_prob(prob_low);
            default: it.random_draw = near_prob(prob_high);
        endcase
        return it;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR: %s", msg);
        err_cnt++;
    endtask

    task automatic add_row(input logic [1:0] func, input int row, input int col,
                           input logic sv, input int draw, input logic typed,
                           input logic acc, input logic st, input int e, input int m);
        t_dir_row d;
        d.item.func        = func;
        d.item.row         = COORD_W'(row);
        d.item.col         = COORD_W'(col);
        d.item.spin_value  = sv;
        d.item.random_draw = PROB_BITS'(draw);
        d.typed            = typed;
        d.res.accepted     = acc;
        d.res.status       = st;
        d.res.energy       = ENERGY_W'(e);
        d.res.magnetization = MAG_W'(m);
        directed_rows.push_back(d);
    endtask

    task automatic add_setting(input int side, input int coup, input int plo, input int phi);
        t_lattice_cfg s;
        s.side = SIDE_W'(side);
        s.coup = COUP_W'(coup);
        s.plo  = PROB_W'(plo);
        s.phi  = PROB_W'(phi);
        settings.push_back(s);
    endtask

    // item transaction; valid stays high so the next item can follow back to back
    task automatic send_item(input t_spin_item it, input logic typed, input t_spin_result tres);
        case (items_sent * 3 / total_items)
            0: begin send_idle = 15; recv_idle = 73; end
            1: begin send_idle = 73; recv_idle = 15; end
            default: begin send_idle = 0; recv_idle = 0; end
        endcase
        if (send_idle > 0 && $urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
        i_valid        <= 1'b1;
        i_func         <= it.func;
        i_row          <= it.row;
        i_col          <= it.col;
        i_spin_value   <= it.spin_value;
        i_random_draw  <= it.random_draw;
        item_typed     <= typed;
        item_typed_res <= tres;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    // register write transaction
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop sending and wait for every outstanding result, then let the block settle
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_stall <= (recv_idle > 0) && ($urandom_range(99) < recv_idle);
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_cnt, results_due.size());
        $display("tb_top: FAIL");
        $finish;
    end

    // result check, prediction on accepted items, register tracking
    always @(posedge i_clk) begin
        t_spin_item   it;
        t_spin_result got, want, pred;
        if (!i_rst_n) begin
            side_len  = SIDE_RST;
            coupling  = COUP_RST;
            prob_low  = PROB_LOW_RST;
            prob_high = PROB_HIGH_RST;
            clear_lattice();
        end else begin
            if (o_valid && !i_stall) begin
                got.accepted      = o_accepted;
                got.status        = o_status;
                got.energy        = o_energy;
                got.magnetization = o_magnetization;
                if (results_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result acc=%0b st=%0b e=%0d m=%0d",
                        got.accepted, got.status, $signed(got.energy),
                        $signed(got.magnetization)));
                end else begin
                    want = results_due.pop_front();
                    checked_cnt++;
                    if (got !== want)
                        report_mismatch($sformatf(
                            "result %0d: got acc=%0b st=%0b e=%0d m=%0d, want acc=%0b st=%0b e=%0d m=%0d",
                            checked_cnt, got.accepted, got.status, $signed(got.energy),
                            $signed(got.magnetization), want.accepted, want.status,
                            $signed(want.energy), $signed(want.magnetization)));
                end
            end
            if (i_valid && !o_stall) begin
                it.func        = i_func;
                it.row         = i_row;
                it.col         = i_col;
                it.spin_value  = i_spin_value;
                it.random_draw = i_random_draw;
                pred = metropolis_step(it);
                if (pred.accepted) flips_taken++;
                if (pred.status == STATUS_RANGE) range_errors++;
                if (it.func == FUNC_CLEAR) clears_seen++;
                results_due.push_back(item_typed ? item_typed_res : pred);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                reg_writes++;
                case (i_cfg_index)
                    REG_SIDE_LEN:  side_len  = i_cfg_data[SIDE_W-1:0];
                    REG_COUPLING:  coupling  = i_cfg_data[COUP_W-1:0];
                    REG_PROB_LOW:  prob_low  = i_cfg_data[PROB_W-1:0];
                    REG_PROB_HIGH: prob_high = i_cfg_data[PROB_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // stimulus
    initial begin
        t_spin_result no_res;
        t_lattice_cfg s;
        int p, k;
        no_res = '0;

        // directed rows under the reset registers: side 16, coupling 1
        add_row(FUNC_CLEAR, 0, 0, 1, 0, 1, 0, STATUS_OK, ENERGY_RST, MAG_RST);
        add_row(FUNC_WRITE, 16, 0, 1, 0, 1, 0, STATUS_RANGE, ENERGY_RST, MAG_RST);
        add_row(FUNC_FLIP, 0, 63, 0, 0, 1, 0, STATUS_RANGE, ENERGY_RST, MAG_RST);
        add_row(FUNC_FLIP, 63, 63, 1, 65535, 1, 0, STATUS_RANGE, ENERGY_RST, MAG_RST);
        add_row(FUNC_NOP, 0, 0, 0, 0, 1, 0, STATUS_OK, ENERGY_RST, MAG_RST);
        // energy rise of eight: draw above and below the high probability
        add_row(FUNC_FLIP, 0, 0, 0, 65535, 1, 0, STATUS_OK, ENERGY_RST, MAG_RST);
        add_row(FUNC_FLIP, 0, 0, 0, 0, 1, 1, STATUS_OK, -504, 254);
        // writing the held value changes nothing, writing the other one flips; then a draw at the high probability
        add_row(FUNC_WRITE, 0, 0, 0, 0, 1, 0, STATUS_OK, -504, 254);
        add_row(FUNC_WRITE, 0, 0, 1, 0, 1, 0, STATUS_OK, ENERGY_RST, MAG_RST);
        add_row(FUNC_FLIP, 0, 0, 1, 22, 1, 1, STATUS_OK, -504, 254);
        // energy drop always taken, then a rise with the draw just above the high probability
        add_row(FUNC_FLIP, 0, 0, 1, 65535, 1, 1, STATUS_OK, ENERGY_RST, MAG_RST);
        add_row(FUNC_FLIP, 0, 0, 1, 23, 1, 0, STATUS_OK, ENERGY_RST, MAG_RST);
        add_row(FUNC_WRITE, 0, 1, 0, 0, 0, 0, STATUS_OK, 0, 0);
        add_row(FUNC_WRITE, 1, 0, 0, 0, 0, 0, STATUS_OK, 0, 0);
        // zero energy change
        add_row(FUNC_FLIP, 0, 0, 0, 65535, 0, 0, STATUS_OK, 0, 0);
        // energy rise of four against the low probability, at the wrapped corner
        add_row(FUNC_WRITE, 14, 15, 0, 0, 0, 0, STATUS_OK, 0, 0);
        add_row(FUNC_FLIP, 15, 15, 1, 1201, 0, 0, STATUS_OK, 0, 0);
        add_row(FUNC_FLIP, 15, 15, 0, 1200, 0, 0, STATUS_OK, 0, 0);
        add_row(FUNC_FLIP, 15, 0, 1, 65535, 0, 0, STATUS_OK, 0, 0);
        add_row(FUNC_WRITE, 63, 0, 1, 0, 0, 0, STATUS_OK, 0, 0);
        add_row(FUNC_NOP, 63, 63, 1, 65535, 0, 0, STATUS_OK, 0, 0);
        add_row(FUNC_CLEAR, 63, 63, 1, 65535, 1, 0, STATUS_OK, ENERGY_RST, MAG_RST);

        // register settings: extremes of side and probabilities, a range of couplings
        add_setting(2, 1, 30000, 5000);
        add_setting(64, -8, 0, 0);
        add_setting(3, 8, 65536, 131071);
        add_setting(1, -1, 20000, 65535);
        add_setting(127, 0, 65535, 1);
        add_setting(0, 7, 1200, 22);
        add_setting(5, 3, 40000, 10000);
        add_setting(8, -2, 1200, 22);
        for (k = 0; k < PHASES - 8; k++)
            add_setting($urandom_range(2, 24), int'($urandom_range(31)) - 16,
                        $urandom_range(131071), $urandom_range(65536));

        total_items = directed_rows.size() + PHASES * ITEMS_PER_PHASE;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].res);

        // random phases, each under its own register setting
        for (p = 0; p < PHASES; p++) begin
            drain_results();
            s = settings[p];
            write_reg(REG_SIDE_LEN, CFG_W'(s.side));
            write_reg(REG_COUPLING, {{(CFG_W-COUP_W){1'b0}}, s.coup});
            write_reg(REG_PROB_LOW, s.plo);
            write_reg(REG_PROB_HIGH, s.phi);
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (k == 0 && p % 2 == 0)
                    send_item('{func: FUNC_CLEAR, row: '0, col: '0, spin_value: 1'b0,
                                random_draw: '0}, 1'b0, no_res);
                else
                    send_item(random_item(), 1'b0, no_res);
            end
        end

        drain_results();
        if (results_due.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived", results_due.size()));

        $display("summary: %0d items (%0d directed) over %0d register settings, %0d results checked",
                 items_sent, directed_rows.size(), PHASES, checked_cnt);
        $display("summary: %0d flips taken, %0d range errors, %0d clears, %0d register writes",
                 flips_taken, range_errors, clears_seen, reg_writes);
        if (err_cnt == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
